// ----- rtl/socks5_client_connect_handshake_core_defines.svh -----
// Assertion helpers for the handshake core, clocked on aclk, off in reset.
`ifndef SOCKS5_CLIENT_CONNECT_HANDSHAKE_CORE_DEFINES_SVH
`define SOCKS5_CLIENT_CONNECT_HANDSHAKE_CORE_DEFINES_SVH

`define S5HS_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("s5hs: forbidden condition seen");

`define S5HS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("s5hs: implication violated");

`endif

// ----- rtl/s5hs_pkg.sv -----
package s5hs_pkg;

    localparam int ADDRESS_LENGTH_DEF = 56;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_RX    = 2'd2;
    localparam logic [1:0] ACT_CLOSE = 2'd3;

    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_INVALID = 4'd9;
    localparam logic [3:0] ST_CLOSED  = 4'd10;
    localparam logic [3:0] ST_AUTH    = 4'd11;

    localparam logic [1:0] CMD_METHOD  = 2'd0;
    localparam logic [1:0] CMD_REQUEST = 2'd1;
    localparam logic [1:0] CMD_FINISH  = 2'd2;

    localparam logic [7:0] SOCKS_VER     = 8'h05;
    localparam logic [7:0] CMD_CONNECT   = 8'h01;
    localparam logic [7:0] METHOD_NOAUTH = 8'h00;
    localparam logic [7:0] RSV_BYTE      = 8'h00;
    localparam logic [7:0] NMETHODS      = 8'h01;
    localparam logic [7:0] ATYP_IPV4     = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
    localparam logic [7:0] ATYP_IPV6     = 8'h04;
    localparam logic [7:0] REP_MAX       = 8'h08;

    localparam logic [8:0] REPLY_LEN_IPV4  = 9'd10;
    localparam logic [8:0] REPLY_LEN_IPV6  = 9'd22;
    localparam logic [8:0] REPLY_LEN_DBASE = 9'd7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  status;
        logic [15:0] port;
    } cmd_t;

    typedef struct packed {
        logic       en;
        logic [5:0] addr;
        logic [7:0] data;
    } wr_t;

endpackage

// ----- rtl/s5hs_queue.sv -----
module s5hs_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  s5hs_pkg::cmd_t push_cmd,
    input  logic          pop,
    output s5hs_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);
    import s5hs_pkg::*;

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [QPW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;

    assign full  = (count_reg == QCW'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/s5hs_front.sv -----
module s5hs_front #(
    parameter int ADDRESS_LENGTH = s5hs_pkg::ADDRESS_LENGTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_action,
    input  logic [5:0]    s_addr_index,
    input  logic [7:0]    s_data_byte,
    input  logic [15:0]   s_dest_port,
    input  logic          q_full,
    input  logic          back_quiet,
    output logic          push,
    output s5hs_pkg::cmd_t push_cmd,
    output s5hs_pkg::wr_t  wr
);
    import s5hs_pkg::*;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_AUTH    = 2'd1;
    localparam logic [1:0] PH_CONNECT = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [8:0]  reply_count_reg, reply_count_next;
    logic [8:0]  reply_total_reg, reply_total_next;
    logic [7:0]  first_auth_reg, first_auth_next;
    logic [15:0] saved_port_reg, saved_port_next;

    logic        accept;
    logic        do_fin;
    logic [3:0]  fin_status;
    logic        bad_type;
    logic [8:0]  cnt_inc;
    logic [8:0]  total_tmp;

    assign s_ready = !q_full && ((s_action != ACT_LOAD) || back_quiet);
    assign accept  = s_valid && s_ready;
    assign cnt_inc = reply_count_reg + 9'd1;

    assign wr.en   = accept && (s_action == ACT_LOAD) && (s_addr_index < 6'(ADDRESS_LENGTH));
    assign wr.addr = s_addr_index;
    assign wr.data = s_data_byte;

    always_comb begin
        phase_next       = phase_reg;
        reply_count_next = reply_count_reg;
        reply_total_next = reply_total_reg;
        first_auth_next  = first_auth_reg;
        saved_port_next  = saved_port_reg;
        push             = 1'b0;
        push_cmd.kind    = CMD_FINISH;
        push_cmd.status  = ST_OK;
        push_cmd.port    = saved_port_reg;
        do_fin           = 1'b0;
        fin_status       = ST_OK;
        bad_type         = 1'b0;
        total_tmp        = reply_total_reg;

        if (accept) begin
            case (s_action)
                ACT_START: begin
                    saved_port_next  = s_dest_port;
                    phase_next       = PH_AUTH;
                    reply_count_next = '0;
                    reply_total_next = '0;
                    first_auth_next  = '0;
                    push             = 1'b1;
                    push_cmd.kind    = CMD_METHOD;
                end
                ACT_CLOSE: begin
                    if (phase_reg != PH_IDLE) begin
                        do_fin     = 1'b1;
                        fin_status = ST_CLOSED;
                    end
                end
                ACT_RX: begin
                    if (phase_reg == PH_AUTH) begin
                        if (reply_count_reg == '0) begin
                            first_auth_next  = s_data_byte;
                            reply_count_next = 9'd1;
                        end else if (first_auth_reg != SOCKS_VER
                                     || s_data_byte != METHOD_NOAUTH) begin
                            do_fin     = 1'b1;
                            fin_status = ST_AUTH;
                        end else begin
                            phase_next       = PH_CONNECT;
                            reply_count_next = '0;
                            reply_total_next = '0;
                            push             = 1'b1;
                            push_cmd.kind    = CMD_REQUEST;
                        end
                    end else if (phase_reg == PH_CONNECT) begin
                        if (reply_count_reg == 9'd0 && s_data_byte != SOCKS_VER) begin
                            do_fin     = 1'b1;
                            fin_status = ST_INVALID;
                        end else if (reply_count_reg == 9'd1 && s_data_byte != 8'h00) begin
                            do_fin     = 1'b1;
                            fin_status = (s_data_byte <= REP_MAX) ? s_data_byte[3:0]
                                                                  : ST_INVALID;
                        end else begin
                            if (reply_count_reg == 9'd3) begin
                                if (s_data_byte == ATYP_IPV4) begin
                                    total_tmp = REPLY_LEN_IPV4;
                                end else if (s_data_byte == ATYP_IPV6) begin
                                    total_tmp = REPLY_LEN_IPV6;
                                end else if (s_data_byte == ATYP_DOMAIN) begin
                                    total_tmp = '0;
                                end else begin
                                    bad_type = 1'b1;
                                end
                            end else if (reply_count_reg == 9'd4 && reply_total_reg == '0) begin
                                total_tmp = REPLY_LEN_DBASE + {1'b0, s_data_byte};
                            end
                            if (bad_type) begin
                                do_fin     = 1'b1;
                                fin_status = ST_INVALID;
                            end else begin
                                reply_count_next = cnt_inc;
                                reply_total_next = total_tmp;
                                if (reply_count_reg >= 9'd4 && cnt_inc == total_tmp) begin
                                    do_fin     = 1'b1;
                                    fin_status = ST_OK;
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (do_fin) begin
            push             = 1'b1;
            push_cmd.kind    = CMD_FINISH;
            push_cmd.status  = fin_status;
            phase_next       = PH_IDLE;
            reply_count_next = '0;
            reply_total_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            reply_count_reg <= '0;
            reply_total_reg <= '0;
            first_auth_reg  <= '0;
            saved_port_reg  <= '0;
        end else begin
            phase_reg       <= phase_next;
            reply_count_reg <= reply_count_next;
            reply_total_reg <= reply_total_next;
            first_auth_reg  <= first_auth_next;
            saved_port_reg  <= saved_port_next;
        end
    end

endmodule

// ----- rtl/s5hs_back.sv -----
module s5hs_back #(
    parameter int ADDRESS_LENGTH = s5hs_pkg::ADDRESS_LENGTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_empty,
    input  s5hs_pkg::cmd_t q_head,
    output logic           q_pop,
    input  s5hs_pkg::wr_t  wr,
    output logic           idle,
    output logic           m_valid,
    input  logic           m_ready,
    output logic           m_tx_valid,
    output logic [7:0]     m_tx_byte,
    output logic           m_last,
    output logic           m_done_res,
    output logic [3:0]     m_status
);
    import s5hs_pkg::*;

    localparam int AW      = (ADDRESS_LENGTH > 1) ? $clog2(ADDRESS_LENGTH) : 1;
    localparam int HDR_LEN = 5;
    localparam int REQ_LEN = ADDRESS_LENGTH + HDR_LEN + 2;
    localparam int PW      = $clog2(REQ_LEN);

    logic [7:0]    mem [ADDRESS_LENGTH];
    logic [7:0]    rd_data_reg;
    logic [PW-1:0] rd_off;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    logic          busy_reg, busy_next;
    logic [1:0]    kind_reg, kind_next;
    logic [3:0]    status_reg, status_next;
    logic [15:0]   port_reg, port_next;
    logic [PW-1:0] pos_reg, pos_next;

    logic          m_valid_reg, m_valid_next;
    logic          tx_valid_reg, done_reg, last_reg;
    logic [7:0]    tx_byte_reg;
    logic [3:0]    out_status_reg;

    logic          out_free;
    logic          emit;
    logic          w_tx_valid, w_last, w_done;
    logic [7:0]    w_byte;
    logic [3:0]    w_status;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = !busy_reg && !q_empty;
    assign emit     = busy_reg && out_free;
    assign idle     = !busy_reg;

    assign m_valid    = m_valid_reg;
    assign m_tx_valid = tx_valid_reg;
    assign m_tx_byte  = tx_byte_reg;
    assign m_last     = last_reg;
    assign m_done_res = done_reg;
    assign m_status   = out_status_reg;

    // address read runs one step ahead of the word counter
    assign rd_off  = pos_next - PW'(HDR_LEN);
    assign rd_en   = rd_off < PW'(ADDRESS_LENGTH);
    assign rd_addr = rd_off[AW-1:0];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        w_tx_valid = 1'b1;
        w_byte     = 8'h00;
        w_last     = 1'b0;
        w_done     = 1'b0;
        w_status   = ST_OK;
        case (kind_reg)
            CMD_METHOD: begin
                if (pos_reg == PW'(0)) begin
                    w_byte = SOCKS_VER;
                end else if (pos_reg == PW'(1)) begin
                    w_byte = NMETHODS;
                end else begin
                    w_byte = METHOD_NOAUTH;
                end
                w_last = (pos_reg == PW'(2));
            end
            CMD_REQUEST: begin
                if (pos_reg == PW'(0)) begin
                    w_byte = SOCKS_VER;
                end else if (pos_reg == PW'(1)) begin
                    w_byte = CMD_CONNECT;
                end else if (pos_reg == PW'(2)) begin
                    w_byte = RSV_BYTE;
                end else if (pos_reg == PW'(3)) begin
                    w_byte = ATYP_DOMAIN;
                end else if (pos_reg == PW'(4)) begin
                    w_byte = 8'(ADDRESS_LENGTH);
                end else if (pos_reg < PW'(ADDRESS_LENGTH + HDR_LEN)) begin
                    w_byte = rd_data_reg;
                end else if (pos_reg == PW'(ADDRESS_LENGTH + HDR_LEN)) begin
                    w_byte = port_reg[15:8];
                end else begin
                    w_byte = port_reg[7:0];
                end
                w_last = (pos_reg == PW'(REQ_LEN - 1));
            end
            default: begin
                w_tx_valid = 1'b0;
                w_last     = 1'b1;
                w_done     = 1'b1;
                w_status   = status_reg;
            end
        endcase
    end

    always_comb begin
        busy_next    = busy_reg;
        kind_next    = kind_reg;
        status_next  = status_reg;
        port_next    = port_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (q_pop) begin
            busy_next   = 1'b1;
            kind_next   = q_head.kind;
            status_next = q_head.status;
            port_next   = q_head.port;
            pos_next    = '0;
        end else if (emit) begin
            m_valid_next = 1'b1;
            pos_next     = pos_reg + PW'(1);
            if (w_last) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            kind_reg    <= CMD_FINISH;
            pos_reg     <= '0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            kind_reg    <= kind_next;
            pos_reg     <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        port_reg   <= port_next;
        if (emit) begin
            tx_valid_reg   <= w_tx_valid;
            tx_byte_reg    <= w_byte;
            last_reg       <= w_last;
            done_reg       <= w_done;
            out_status_reg <= w_status;
        end
    end

endmodule

// ----- rtl/socks5_client_connect_handshake_core.sv -----
// Results pass the command queue, the emitter state and then the output register.
// Throughput: one input word per cycle while s_ready is high; results stream at
// one word per cycle while m_ready allows, with a pause between queued commands.
// A connect request is ADDRESS_LENGTH + 7 words, paced by the address store read port.
// Address loads wait until the command queue and the emitter are drained.
// Reset: aresetn synchronous, active low; clears phase, counters, queue and output valid.
// The address store is not cleared by reset.
`include "socks5_client_connect_handshake_core_defines.svh"

module socks5_client_connect_handshake_core #(
    parameter int ADDRESS_LENGTH = s5hs_pkg::ADDRESS_LENGTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [5:0]  s_addr_index,
    input  logic [7:0]  s_data_byte,
    input  logic [15:0] s_dest_port,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_tx_valid,
    output logic [7:0]  m_tx_byte,
    output logic        m_last,
    output logic        m_done_res,
    output logic [3:0]  m_status
);
    import s5hs_pkg::*;

    logic q_push, q_pop, q_full, q_empty;
    cmd_t q_in, q_head;
    wr_t  wr;
    logic back_idle;
    logic back_quiet;

    assign back_quiet = back_idle && q_empty;

    s5hs_front #(
        .ADDRESS_LENGTH(ADDRESS_LENGTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_addr_index (s_addr_index),
        .s_data_byte  (s_data_byte),
        .s_dest_port  (s_dest_port),
        .q_full       (q_full),
        .back_quiet   (back_quiet),
        .push         (q_push),
        .push_cmd     (q_in),
        .wr           (wr)
    );

    s5hs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_in),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    s5hs_back #(
        .ADDRESS_LENGTH(ADDRESS_LENGTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .wr         (wr),
        .idle       (back_idle),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_tx_valid (m_tx_valid),
        .m_tx_byte  (m_tx_byte),
        .m_last     (m_last),
        .m_done_res (m_done_res),
        .m_status   (m_status)
    );

    `S5HS_ASSERT_NEVER(a_queue_overflow, q_push && q_full)
    `S5HS_ASSERT_IMPL(a_load_when_quiet, s_valid && s_ready && (s_action == ACT_LOAD), back_quiet)
    `S5HS_ASSERT_IMPL(a_done_word_shape, m_valid && m_done_res, !m_tx_valid && m_last)

endmodule

// ----- tb/tb_socks5_client_connect_handshake_core.sv -----
`timescale 1ns / 1ps

module tb_socks5_client_connect_handshake_core;
    import s5hs_pkg::*;

    localparam int ADDR_LEN = ADDRESS_LENGTH_DEF;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  addr_index;
        logic [7:0]  data_byte;
        logic [15:0] dest_port;
    } in_word_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       last;
        logic       done_res;
        logic [3:0] status;
    } out_word_t;

    typedef enum logic [1:0] {PH_IDLE, PH_AUTH, PH_CONNECT} hs_phase_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = ACT_LOAD;
    logic [5:0]  s_addr_index = 6'd0;
    logic [7:0]  s_data_byte = 8'd0;
    logic [15:0] s_dest_port = 16'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_tx_valid;
    logic [7:0]  m_tx_byte;
    logic        m_last;
    logic        m_done_res;
    logic [3:0]  m_status;

    in_word_t  host_words[$];
    out_word_t core_out[$];
    int        host_count = 0;
    int        host_gap = 0;
    bit        host_taken = 1'b0;
    int        sink_gap = 0;
    bit        sink_hold = 1'b0;
    bit        calm = 1'b0;
    int        results_seen = 0;
    int        bad_words = 0;

    hs_phase_t  hs_phase = PH_IDLE;
    logic [7:0] addr_mem [ADDR_LEN];
    logic [15:0] port_r = 16'd0;
    logic [8:0] rx_cnt = 9'd0;
    logic [8:0] rx_total = 9'd0;
    logic [7:0] auth_b0 = 8'd0;

    socks5_client_connect_handshake_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_addr_index (s_addr_index),
        .s_data_byte  (s_data_byte),
        .s_dest_port  (s_dest_port),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_tx_valid   (m_tx_valid),
        .m_tx_byte    (m_tx_byte),
        .m_last       (m_last),
        .m_done_res   (m_done_res),
        .m_status     (m_status)
    );

    always #1 aclk = ~aclk;

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #20_000_000;
        $display("socks5_client_connect_handshake_core: mismatch");
        $finish;
    end

    // ---------------- handshake prediction ----------------

    task automatic push_word(bit txv, logic [7:0] b, bit lst, bit dn, logic [3:0] st);
        core_out.push_back('{txv, b, lst, dn, st});
    endtask

    task automatic finish_hs(logic [3:0] st);
        push_word(1'b0, 8'h00, 1'b1, 1'b1, st);
        hs_phase = PH_IDLE;
        rx_cnt   = 9'd0;
        rx_total = 9'd0;
    endtask

    task automatic send_request();
        push_word(1'b1, SOCKS_VER, 1'b0, 1'b0, ST_OK);
        push_word(1'b1, CMD_CONNECT, 1'b0, 1'b0, ST_OK);
        push_word(1'b1, RSV_BYTE, 1'b0, 1'b0, ST_OK);
        push_word(1'b1, ATYP_DOMAIN, 1'b0, 1'b0, ST_OK);
        push_word(1'b1, 8'(ADDR_LEN), 1'b0, 1'b0, ST_OK);
        for (int i = 0; i < ADDR_LEN; i++)
            push_word(1'b1, addr_mem[i], 1'b0, 1'b0, ST_OK);
        push_word(1'b1, port_r[15:8], 1'b0, 1'b0, ST_OK);
        push_word(1'b1, port_r[7:0], 1'b1, 1'b0, ST_OK);
    endtask

    task automatic connect_byte(logic [7:0] b);
        logic [8:0] idx;
        bit ended;
        idx = rx_cnt;
        ended = 1'b0;
        if (idx == 9'd0) begin
            if (b != SOCKS_VER) begin
                finish_hs(ST_INVALID);
                ended = 1'b1;
            end
        end else if (idx == 9'd1) begin
            if (b != 8'h00) begin
                finish_hs(b <= REP_MAX ? b[3:0] : ST_INVALID);
                ended = 1'b1;
            end
        end else if (idx == 9'd3) begin
            if (b == ATYP_IPV4)
                rx_total = REPLY_LEN_IPV4;
            else if (b == ATYP_IPV6)
                rx_total = REPLY_LEN_IPV6;
            else if (b == ATYP_DOMAIN)
                rx_total = 9'd0;
            else begin
                finish_hs(ST_INVALID);
                ended = 1'b1;
            end
        end else if (idx == 9'd4 && rx_total == 9'd0) begin
            rx_total = REPLY_LEN_DBASE + {1'b0, b};
        end
        if (!ended) begin
            rx_cnt = rx_cnt + 9'd1;
            if (idx >= 9'd4 && rx_cnt == rx_total)
                finish_hs(ST_OK);
        end
    endtask

    task automatic advance_handshake(in_word_t w);
        if (w.action == ACT_LOAD) begin
            if (w.addr_index < ADDR_LEN)
                addr_mem[w.addr_index] = w.data_byte;
        end else if (w.action == ACT_START) begin
            port_r    = w.dest_port;
            hs_phase  = PH_AUTH;
            rx_cnt    = 9'd0;
            rx_total  = 9'd0;
            auth_b0   = 8'h00;
            push_word(1'b1, SOCKS_VER, 1'b0, 1'b0, ST_OK);
            push_word(1'b1, NMETHODS, 1'b0, 1'b0, ST_OK);
            push_word(1'b1, METHOD_NOAUTH, 1'b1, 1'b0, ST_OK);
        end else if (w.action == ACT_CLOSE) begin
            if (hs_phase != PH_IDLE)
                finish_hs(ST_CLOSED);
        end else begin
            case (hs_phase)
                PH_AUTH: begin
                    if (rx_cnt == 9'd0) begin
                        auth_b0 = w.data_byte;
                        rx_cnt  = 9'd1;
                    end else if (auth_b0 != SOCKS_VER || w.data_byte != METHOD_NOAUTH) begin
                        finish_hs(ST_AUTH);
                    end else begin
                        hs_phase = PH_CONNECT;
                        rx_cnt   = 9'd0;
                        rx_total = 9'd0;
                        send_request();
                    end
                end
                PH_CONNECT: connect_byte(w.data_byte);
                default: ;
            endcase
        end
    endtask

    // ---------------- stimulus ----------------

    task automatic add_item(logic [1:0] a, logic [5:0] ix, logic [7:0] b, logic [15:0] p,
                            bit counted);
        host_words.push_back('{a, ix, b, p});
        if (counted)
            host_count++;
    endtask

    task automatic add_rx(logic [7:0] b);
        add_item(ACT_RX, 6'($urandom), b, 16'($urandom), 1'b1);
    endtask

    task automatic add_start(logic [15:0] p);
        add_item(ACT_START, 6'($urandom), 8'($urandom), p, 1'b1);
    endtask

    task automatic add_close();
        add_item(ACT_CLOSE, 6'($urandom), 8'($urandom), 16'($urandom), 1'b1);
    endtask

    task automatic gen_session();
        logic [7:0] reply[$];
        logic [7:0] atyp;
        logic [7:0] dlen;
        logic [7:0] b0;
        logic [7:0] b1;
        int r;
        int keep;
        bit closing;
        closing = 1'b0;
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 19) == 0)
                add_item(ACT_LOAD, 6'($urandom_range(ADDR_LEN, 63)), 8'($urandom),
                         16'($urandom), 1'b1);
            else
                add_item(ACT_LOAD, 6'($urandom_range(0, ADDR_LEN - 1)), 8'($urandom),
                         16'($urandom), 1'b1);
        end
        add_start(16'($urandom));
        r = $urandom_range(0, 99);
        if (r < 6) begin
            b0 = 8'($urandom);
            b1 = 8'($urandom);
            if (b0 == SOCKS_VER && b1 == METHOD_NOAUTH)
                b1 = 8'hFF;
            add_rx(b0);
            add_rx(b1);
            return;
        end
        if (r < 9) begin
            if (r < 8)
                add_rx(8'($urandom));
            add_close();
            return;
        end
        if (r < 11) begin
            if (r < 10)
                add_rx(SOCKS_VER);
            return;
        end
        add_rx(SOCKS_VER);
        add_rx(METHOD_NOAUTH);

        case ($urandom_range(0, 2))
            0: atyp = ATYP_IPV4;
            1: atyp = ATYP_DOMAIN;
            default: atyp = ATYP_IPV6;
        endcase
        dlen = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 12));
        reply = {SOCKS_VER, 8'h00, 8'($urandom), atyp};
        if (atyp == ATYP_DOMAIN) begin
            reply.push_back(dlen);
            repeat (dlen) reply.push_back(8'($urandom));
        end else begin
            repeat (atyp == ATYP_IPV4 ? 4 : 16) reply.push_back(8'($urandom));
        end
        reply.push_back(8'($urandom));
        reply.push_back(8'($urandom));

        keep = reply.size();
        r = $urandom_range(0, 99);
        if (r < 5) begin
            do b0 = 8'($urandom); while (b0 == SOCKS_VER);
            reply[0] = b0;
            keep = 1;
        end else if (r < 13) begin
            reply[1] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 8))
                                                   : 8'($urandom_range(9, 255));
            keep = 2;
        end else if (r < 17) begin
            do b0 = 8'($urandom); while (b0 == ATYP_IPV4 || b0 == ATYP_DOMAIN ||
                                         b0 == ATYP_IPV6);
            reply[3] = b0;
            keep = 4;
        end else if (r < 21) begin
            keep = $urandom_range(0, reply.size() - 1);
            closing = 1'b1;
        end else if (r < 23) begin
            keep = $urandom_range(0, reply.size() - 1);
        end
        for (int i = 0; i < keep; i++)
            add_rx(reply[i]);
        if (closing)
            add_close();
    endtask

    initial begin
        for (int i = 0; i < ADDR_LEN; i++)
            add_item(ACT_LOAD, 6'(i), (i == 0) ? 8'h00 : (i == ADDR_LEN - 1) ? 8'hFF
                     : 8'($urandom), 16'($urandom), 1'b1);
        add_item(ACT_LOAD, 6'(ADDR_LEN), 8'hA5, 16'h0000, 1'b1);
        add_item(ACT_LOAD, 6'd63, 8'h5A, 16'hFFFF, 1'b1);
        add_item(ACT_RX, 6'd0, 8'h05, 16'h0000, 1'b0);
        add_item(ACT_CLOSE, 6'd63, 8'hFF, 16'hFFFF, 1'b0);

        add_start(16'hFFFF);
        add_rx(SOCKS_VER);
        add_rx(METHOD_NOAUTH);
        add_rx(SOCKS_VER);
        add_rx(8'h00);
        add_rx(8'hFF);
        add_rx(ATYP_IPV4);
        repeat (4) add_rx(8'($urandom));
        add_rx(8'hFF);
        add_rx(8'h00);

        add_start(16'h0000);
        add_rx(8'h04);
        add_rx(METHOD_NOAUTH);

        add_start(16'h1234);
        add_start(16'h8001);
        add_close();

        while (host_count < 430) begin
            gen_session();
            if ($urandom_range(0, 99) < 20)
                add_item($urandom_range(0, 1) ? ACT_RX : ACT_CLOSE, 6'($urandom),
                         8'($urandom), 16'($urandom), 1'b0);
        end
    end

    // ---------------- drivers ----------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(negedge aclk) begin
        in_word_t w;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || host_taken) begin
            host_taken = 1'b0;
            if (host_gap > 0) begin
                host_gap--;
                s_valid <= 1'b0;
            end else if (host_words.size() != 0) begin
                w = host_words.pop_front();
                s_action     <= w.action;
                s_addr_index <= w.addr_index;
                s_data_byte  <= w.data_byte;
                s_dest_port  <= w.dest_port;
                s_valid      <= 1'b1;
                host_gap = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (sink_hold) begin
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            sink_gap = pick_gap();
        end
    end

    // long receiver stall while words keep coming, then a stretch with no gaps
    initial begin
        wait (results_seen >= 150);
        @(posedge aclk);
        sink_hold = 1'b1;
        repeat (300) @(posedge aclk);
        sink_hold = 1'b0;
        calm = 1'b1;
        repeat (400) @(posedge aclk);
        calm = 1'b0;
    end

    // ---------------- monitor ----------------

    always @(posedge aclk) begin
        out_word_t got;
        out_word_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                advance_handshake('{s_action, s_addr_index, s_data_byte, s_dest_port});
                host_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                got = '{m_tx_valid, m_tx_byte, m_last, m_done_res, m_status};
                if (core_out.size() == 0) begin
                    if (bad_words < 10)
                        $display("result %0d: none expected, got %0b/%02h/%0b/%0b/%0d",
                                 results_seen, got.tx_valid, got.tx_byte, got.last,
                                 got.done_res, got.status);
                    bad_words++;
                end else begin
                    want = core_out.pop_front();
                    if (got !== want) begin
                        if (bad_words < 10)
                            $display("result %0d: exp %0b/%02h/%0b/%0b/%0d got %0b/%02h/%0b/%0b/%0d",
                                     results_seen, want.tx_valid, want.tx_byte, want.last,
                                     want.done_res, want.status, got.tx_valid, got.tx_byte,
                                     got.last, got.done_res, got.status);
                        bad_words++;
                    end
                end
                results_seen++;
            end
        end
    end

    initial begin
        wait (aresetn === 1'b1);
        while (host_words.size() != 0 || s_valid)
            @(posedge aclk);
        while (core_out.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (bad_words == 0 && core_out.size() == 0)
            $display("socks5_client_connect_handshake_core: match");
        else
            $display("socks5_client_connect_handshake_core: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/s5hs_pkg.sv
rtl/s5hs_queue.sv
rtl/s5hs_front.sv
rtl/s5hs_back.sv
rtl/socks5_client_connect_handshake_core.sv
tb/tb_socks5_client_connect_handshake_core.sv
